/* hdl/spsel_pkg.sv */
// Shared types and constants for the streaming percentile select block.
// No dependencies; imported by the front, queue, back and top-level modules and the bench.
package spsel_pkg;

  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FRACTION = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOTAL    = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_DIRECT,
    KIND_INTERP,
    KIND_HELD
  } spsel_kind_t;

endpackage

/* hdl/spsel_front.sv */
// Front stage: configuration registers, input register and target computation.
// Depends on spsel_pkg; feeds spsel_queue with packed entries.
module spsel_front #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int CFG_W   = (COUNT_WIDTH > FRAC_BITS + 1) ? COUNT_WIDTH : FRAC_BITS + 1,
  localparam int TW      = COUNT_WIDTH + 1,
  localparam int ENTRY_W = 2 + VALUE_WIDTH + COUNT_WIDTH + 2 * TW + FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [spsel_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_W-1:0]                       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_group_start,
  input  logic                                   in_is_null,
  input  logic signed [VALUE_WIDTH-1:0]          in_sample_value,
  input  logic [COUNT_WIDTH-1:0]                 in_peer_count,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ENTRY_W-1:0]                     out_entry
);
  import spsel_pkg::*;

  localparam logic [FRAC_BITS:0] FRAC_ONE   = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0] FRAC_RESET = (FRAC_BITS + 1)'(1) << (FRAC_BITS - 1);

  logic                   mode_discrete;
  logic [FRAC_BITS:0]     fraction;
  logic [COUNT_WIDTH-1:0] total_rows;

  logic                   f_gs;
  logic                   f_nul;
  logic [VALUE_WIDTH-1:0] f_value;
  logic [COUNT_WIDTH-1:0] f_count;

  logic [FRAC_BITS:0]             p_sat;
  logic [COUNT_WIDTH-1:0]         t_eff;
  logic [COUNT_WIDTH-1:0]         scale_in;
  logic [COUNT_WIDTH+FRAC_BITS:0] prod;
  logic [TW-1:0]                  whole;
  logic                           rem_nz;
  logic [TW-1:0]                  tgt_floor;
  logic [TW-1:0]                  tgt_ceil;
  logic [FRAC_BITS-1:0]           tgt_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_discrete <= 1'b0;
      fraction      <= FRAC_RESET;
      total_rows    <= COUNT_WIDTH'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MODE:     mode_discrete <= cfg_data[0];
        CFG_FRACTION: fraction      <= cfg_data[FRAC_BITS:0];
        CFG_TOTAL:    total_rows    <= cfg_data[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_gs    <= in_group_start;
      f_nul   <= in_is_null;
      f_value <= in_sample_value;
      f_count <= in_peer_count;
    end
  end

  always_comb begin
    p_sat    = (fraction > FRAC_ONE) ? FRAC_ONE : fraction;
    t_eff    = (total_rows == '0) ? COUNT_WIDTH'(1) : total_rows;
    scale_in = mode_discrete ? t_eff : t_eff - COUNT_WIDTH'(1);
    prod     = {{(FRAC_BITS + 1){1'b0}}, scale_in} * {{COUNT_WIDTH{1'b0}}, p_sat};
    whole    = prod[COUNT_WIDTH+FRAC_BITS:FRAC_BITS];
    rem_nz   = |prod[FRAC_BITS-1:0];
    if (mode_discrete) begin
      tgt_floor = (p_sat == '0) ? TW'(1) : whole + TW'(rem_nz);
      tgt_ceil  = tgt_floor;
      tgt_frac  = '0;
    end else begin
      tgt_floor = whole + TW'(1);
      tgt_ceil  = tgt_floor + TW'(rem_nz);
      tgt_frac  = prod[FRAC_BITS-1:0];
    end
  end

  assign out_entry = {f_gs, f_nul, f_value, f_count, tgt_floor, tgt_ceil, tgt_frac};

endmodule

/* hdl/spsel_queue.sv */
// Small FIFO between the front and back stages of the percentile select block.
// Imports spsel_pkg directly, though it uses none of its items.
module spsel_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 2) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_entry,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_entry
);
  import spsel_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign in_ready  = count != CW'(DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

/* hdl/spsel_back.sv */
// Back stage: row tracking, target match, interpolation and output register.
// Depends on spsel_pkg; takes entries from spsel_queue.
module spsel_back #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int TW      = COUNT_WIDTH + 1,
  localparam int PW      = COUNT_WIDTH + 2,
  localparam int ENTRY_W = 2 + VALUE_WIDTH + COUNT_WIDTH + 2 * TW + FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ENTRY_W-1:0]            in_entry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic signed [VALUE_WIDTH-1:0] out_answer
);
  import spsel_pkg::*;

  logic                   e_gs;
  logic                   e_nul;
  logic [VALUE_WIDTH-1:0] e_value;
  logic [COUNT_WIDTH-1:0] e_count;
  logic [TW-1:0]          e_floor;
  logic [TW-1:0]          e_ceil;
  logic [FRAC_BITS-1:0]   e_frac;

  logic [PW-1:0]          row_pos;
  logic [TW-1:0]          t_floor;
  logic [TW-1:0]          t_ceil;
  logic [FRAC_BITS-1:0]   t_frac;
  logic [VALUE_WIDTH-1:0] prev;
  logic                   done;

  logic [PW-1:0]          r0;
  logic [TW-1:0]          tf_eff;
  logic [TW-1:0]          tc_eff;
  logic [FRAC_BITS-1:0]   fr_eff;
  logic [VALUE_WIDTH-1:0] prev_eff;
  logic                   done_eff;
  logic [PW:0]            rn1;
  logic [PW-1:0]          row_sat;
  logic                   le_floor;
  logic                   gt_floor;
  logic                   gt_ceil;
  logic                   ge_ceil;
  logic [VALUE_WIDTH:0]   diff;

  logic [PW-1:0]          row_next;
  logic [VALUE_WIDTH-1:0] prev_next;
  logic                   done_next;
  spsel_kind_t            kind;
  logic [VALUE_WIDTH-1:0] a_sel;
  logic                   up_sel;
  logic [VALUE_WIDTH:0]   mag_sel;

  logic                   p1_valid;
  spsel_kind_t            p1_kind;
  logic [VALUE_WIDTH-1:0] p1_a;
  logic                   p1_up;
  logic [VALUE_WIDTH:0]   p1_mag;
  logic [FRAC_BITS-1:0]   p1_frac;
  logic                   p1_ready;
  logic                   p2_ready;
  logic                   pop;

  logic [VALUE_WIDTH+FRAC_BITS:0] prod;
  logic [VALUE_WIDTH-1:0]         q;
  logic                           r_nz;
  logic [VALUE_WIDTH-1:0]         res;
  logic [VALUE_WIDTH-1:0]         held;

  assign {e_gs, e_nul, e_value, e_count, e_floor, e_ceil, e_frac} = in_entry;

  assign p2_ready = !out_valid || out_ready;
  assign p1_ready = !p1_valid || p2_ready;
  assign in_ready = p1_ready;
  assign pop      = in_valid && p1_ready;

  always_comb begin
    if (e_gs) begin
      r0       = PW'(1);
      tf_eff   = e_floor;
      tc_eff   = e_ceil;
      fr_eff   = e_frac;
      prev_eff = '0;
      done_eff = 1'b0;
    end else begin
      r0       = row_pos;
      tf_eff   = t_floor;
      tc_eff   = t_ceil;
      fr_eff   = t_frac;
      prev_eff = prev;
      done_eff = done;
    end
    rn1      = {1'b0, r0} + {{(PW + 1 - COUNT_WIDTH){1'b0}}, e_count};
    row_sat  = rn1[PW] ? '1 : rn1[PW-1:0];
    le_floor = r0 <= {{(PW - TW){1'b0}}, tf_eff};
    ge_ceil  = r0 >= {{(PW - TW){1'b0}}, tc_eff};
    gt_floor = rn1 > {{(PW + 1 - TW){1'b0}}, tf_eff};
    gt_ceil  = rn1 > {{(PW + 1 - TW){1'b0}}, tc_eff};
    diff     = {e_value[VALUE_WIDTH-1], e_value} - {prev_eff[VALUE_WIDTH-1], prev_eff};

    row_next  = r0;
    prev_next = prev_eff;
    done_next = done_eff;
    kind      = done_eff ? KIND_HELD : KIND_NONE;
    a_sel     = e_value;
    up_sel    = 1'b1;
    mag_sel   = '0;
    if (!done_eff && !e_nul) begin
      row_next = row_sat;
      priority if (le_floor && gt_ceil) begin
        kind      = KIND_DIRECT;
        done_next = 1'b1;
      end else if (le_floor && gt_floor) begin
        prev_next = e_value;
      end else if (ge_ceil) begin
        kind      = KIND_INTERP;
        done_next = 1'b1;
        a_sel     = prev_eff;
        up_sel    = ~diff[VALUE_WIDTH];
        mag_sel   = diff[VALUE_WIDTH] ? (~diff + (VALUE_WIDTH + 1)'(1)) : diff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= PW'(1);
      t_floor <= '0;
      t_ceil  <= '0;
      t_frac  <= '0;
      prev    <= '0;
      done    <= 1'b0;
    end else if (pop) begin
      row_pos <= row_next;
      t_floor <= tf_eff;
      t_ceil  <= tc_eff;
      t_frac  <= fr_eff;
      prev    <= prev_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (p1_ready) begin
      p1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p1_kind <= kind;
      p1_a    <= a_sel;
      p1_up   <= up_sel;
      p1_mag  <= mag_sel;
      p1_frac <= fr_eff;
    end
  end

  always_comb begin
    prod = {{FRAC_BITS{1'b0}}, p1_mag} * {{(VALUE_WIDTH + 1){1'b0}}, p1_frac};
    q    = prod[VALUE_WIDTH+FRAC_BITS-1:FRAC_BITS];
    r_nz = |prod[FRAC_BITS-1:0];
    res  = p1_up ? p1_a + q : p1_a - q - VALUE_WIDTH'(r_nz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p2_ready) begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid && p2_ready) begin
      unique case (p1_kind)
        KIND_NONE: begin
          out_found  <= 1'b0;
          out_answer <= '0;
        end
        KIND_DIRECT, KIND_INTERP: begin
          out_found  <= 1'b1;
          out_answer <= res;
          held       <= res;
        end
        KIND_HELD: begin
          out_found  <= 1'b1;
          out_answer <= held;
        end
        default: begin
          out_found  <= 1'b0;
          out_answer <= '0;
        end
      endcase
    end
  end

endmodule

/* hdl/streaming_percentile_select_top.sv */
// Streaming percentile select: top level joining front, queue and back stages.
// Depends on spsel_pkg, spsel_front, spsel_queue and spsel_back.
//
// Usage: sorted values arrive on s_axis with their peer counts; every accepted
// transaction yields exactly one result transaction on m_axis, in order.
// s_axis_tuser[0] opens a new group (state cleared, targets taken from the
// registers at that moment); s_axis_tuser[1] marks a null item, which moves
// no rows. m_axis_tuser[0] is the found flag; tdata is zero while not found.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index (0 mode,
// 1 fraction, 2 total rows) at the clock edge; write only while idle.
// Path: the front input register, the queue, then the back stage's row tracker and output register.
// Throughput: one transaction per cycle while m_axis_tready holds high; the row tracker
// in the back stage updates the running row position once per item.
// Stall: a 2-entry queue decouples the front register from the back
// pipeline; s_axis_tready drops once the front register and queue are full
// and the back stage is held by m_axis_tready.
// Reset (rst, synchronous): registers return to mode 0, fraction one half,
// total rows 1; all in-flight transactions are dropped.
module streaming_percentile_select_top #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int CFG_W      = (COUNT_WIDTH > FRAC_BITS + 1) ? COUNT_WIDTH : FRAC_BITS + 1,
  localparam int IN_DATA_W  = ((VALUE_WIDTH + COUNT_WIDTH + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [spsel_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_W-1:0]                      cfg_data,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]                  s_axis_tdata,  // sample_value, peers
  input  logic [1:0]                            s_axis_tuser,  // group_start, is_null
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]                 m_axis_tdata,  // answer
  output logic [0:0]                            m_axis_tuser   // found
);
  import spsel_pkg::*;

  localparam int TW      = COUNT_WIDTH + 1;
  localparam int ENTRY_W = 2 + VALUE_WIDTH + COUNT_WIDTH + 2 * TW + FRAC_BITS;

  logic                   fq_valid;
  logic                   fq_ready;
  logic [ENTRY_W-1:0]     fq_entry;
  logic                   qb_valid;
  logic                   qb_ready;
  logic [ENTRY_W-1:0]     qb_entry;
  logic                   found;
  logic [VALUE_WIDTH-1:0] answer;

  spsel_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .in_group_start  (s_axis_tuser[0]),
    .in_is_null      (s_axis_tuser[1]),
    .in_sample_value (s_axis_tdata[VALUE_WIDTH-1:0]),
    .in_peer_count   (s_axis_tdata[VALUE_WIDTH+COUNT_WIDTH-1:VALUE_WIDTH]),
    .out_valid       (fq_valid),
    .out_ready       (fq_ready),
    .out_entry       (fq_entry)
  );

  spsel_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_entry  (fq_entry),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_entry (qb_entry)
  );

  spsel_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (qb_valid),
    .in_ready   (qb_ready),
    .in_entry   (qb_entry),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_found  (found),
    .out_answer (answer)
  );

  assign m_axis_tdata    = OUT_DATA_W'(answer);
  assign m_axis_tuser[0] = found;

`ifndef SYNTH
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    !fq_ready |-> qb_valid)
    else $error("queue reports full while empty");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_null_answer_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("nonzero answer without found");
`endif

endmodule

/* sim/streaming_percentile_select_top_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for streaming_percentile_select_top: a directed table, then random sorted
// groups under random idling, results checked against the table or an in-bench percentile tracker.
// Depends on spsel_pkg and the streaming_percentile_select_top RTL.
module streaming_percentile_select_top_test;
  import spsel_pkg::*;

  typedef struct packed {
    bit          gs;
    bit          nul;
    logic [31:0] value;
    logic [31:0] count;
  } sample_t;

  typedef struct packed {
    bit          found;
    logic [31:0] answer;
  } result_t;

  typedef enum bit {ROW_ITEM, ROW_CONFIG} row_kind_t;

  // config rows carry mode in gs, fraction in value, total rows in count
  typedef struct packed {
    row_kind_t   kind;
    bit          gs;
    bit          nul;
    logic [31:0] value;
    logic [31:0] count;
    bit          typed;
    bit          exp_found;
    logic [31:0] exp_answer;
  } row_t;

  localparam int DIR_ROWS = 29;

  row_t dir_tab [DIR_ROWS] = '{
    '{ROW_ITEM,   1'b0, 1'b1, 32'h0000_0005, 32'h0000_0001, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b0, 1'b0, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 1'b1, 32'h0000_0000},
    '{ROW_ITEM,   1'b0, 1'b0, 32'h0000_0003, 32'h0000_0002, 1'b1, 1'b1, 32'h0000_0000},
    '{ROW_ITEM,   1'b1, 1'b1, 32'h0000_0009, 32'h0000_0001, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b0, 1'b0, 32'h8000_0000, 32'h0000_0001, 1'b1, 1'b1, 32'h8000_0000},
    '{ROW_ITEM,   1'b0, 1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000},
    '{ROW_CONFIG, 1'b0, 1'b0, 32'h0000_4000, 32'h0000_0005, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b1, 1'b0, 32'h000A_0000, 32'h0000_0001, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b0, 1'b0, 32'h0014_0000, 32'h0000_0003, 1'b1, 1'b1, 32'h0014_0000},
    '{ROW_CONFIG, 1'b0, 1'b0, 32'h0000_8000, 32'h0000_0004, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b1, 1'b0, 32'h0000_0001, 32'h0000_0001, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b0, 1'b0, 32'hFFFF_FFFD, 32'h0000_0001, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b0, 1'b0, 32'h0000_0004, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b1, 1'b0, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b0, 1'b0, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b0, 1'b0, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b1, 1'b0, 32'h7FFF_FFFF, 32'h0000_0002, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b0, 1'b0, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_CONFIG, 1'b1, 1'b0, 32'h0000_0000, 32'h0000_0007, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b1, 1'b0, 32'h0000_0007, 32'h0000_0001, 1'b1, 1'b1, 32'h0000_0007},
    '{ROW_CONFIG, 1'b1, 1'b0, 32'h0001_0000, 32'h0000_0003, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b1, 1'b0, 32'h0000_0001, 32'h0000_0002, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b0, 1'b0, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_CONFIG, 1'b1, 1'b0, 32'h0001_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b1, 1'b0, 32'h0000_0009, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0009},
    '{ROW_CONFIG, 1'b0, 1'b0, 32'h0001_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b1, 1'b0, 32'hFFFF_0000, 32'hFFFF_FFFE, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM,   1'b0, 1'b0, 32'h0001_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0001_0000}
  };

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  bit        cur_mode;
  logic [16:0] cur_fraction;
  logic [31:0] cur_total;
  logic [33:0] pos_row;
  logic [32:0] floor_row;
  logic [32:0] ceil_row;
  logic [15:0] ceil_frac;
  logic [31:0] floor_value;
  logic [31:0] held_value;
  bit          value_known;

  result_t pending_answers [$];
  int      mismatch_count;
  bit      send_burst;
  bit      recv_burst;
  bit      hold_req;

  streaming_percentile_select_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void open_group();
    pos_row     = 34'd1;
    floor_row   = '0;
    ceil_row    = '0;
    ceil_frac   = '0;
    floor_value = '0;
    held_value  = '0;
    value_known = 1'b0;
  endfunction

  function automatic void load_targets();
    logic [16:0] p;
    logic [31:0] t;
    logic [63:0] prod;
    p = (cur_fraction > 17'h10000) ? 17'h10000 : cur_fraction;
    t = (cur_total == 32'd0) ? 32'd1 : cur_total;
    if (cur_mode) begin
      prod = 64'(t) * 64'(p);
      if (p == 17'd0) begin
        floor_row = 33'd1;
      end else begin
        floor_row = 33'(prod[63:16]) + 33'(prod[15:0] != 16'd0);
      end
      ceil_row  = floor_row;
      ceil_frac = '0;
    end else begin
      prod = 64'(t - 32'd1) * 64'(p);
      floor_row = 33'(prod[63:16]) + 33'd1;
      ceil_frac = prod[15:0];
      ceil_row  = floor_row + 33'(prod[15:0] != 16'd0);
    end
  endfunction

  function automatic void percentile_step(input sample_t s, output result_t r);
    logic [33:0] rn0;
    logic [34:0] rn1;
    longint      diff;
    longint      scaled;
    if (s.gs) begin
      open_group();
      load_targets();
    end
    if (!value_known && !s.nul) begin
      rn0 = pos_row;
      rn1 = 35'(rn0) + 35'(s.count);
      pos_row = (rn1 > 35'h3_FFFF_FFFF) ? 34'h3_FFFF_FFFF : rn1[33:0];
      if (rn0 <= floor_row && rn1 > ceil_row) begin
        held_value  = s.value;
        value_known = 1'b1;
      end else if (rn0 <= floor_row && rn1 > floor_row) begin
        floor_value = s.value;
      end else if (rn0 >= ceil_row) begin
        diff   = longint'($signed(s.value)) - longint'($signed(floor_value));
        scaled = (diff * longint'(ceil_frac)) >>> 16;
        held_value  = 32'(longint'($signed(floor_value)) + scaled);
        value_known = 1'b1;
      end
    end
    r.found  = value_known;
    r.answer = value_known ? held_value : 32'd0;
  endfunction

  task automatic offer_sample(input sample_t s, input bit typed, input result_t typed_res);
    int      gap;
    result_t predicted;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {s.count, s.value};
    s_axis_tuser  <= {s.nul, s.gs};
    do @(posedge clk); while (!s_axis_tready);
    percentile_step(s, predicted);
    pending_answers.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_results();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_settings(input bit mode, input logic [16:0] frac,
                                input logic [31:0] total);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= {31'd0, mode};
    @(posedge clk);
    cfg_index <= CFG_FRACTION;
    cfg_data  <= 32'(frac);
    @(posedge clk);
    cfg_index <= CFG_TOTAL;
    cfg_data  <= total;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode     = mode;
    cur_fraction = frac;
    cur_total    = total;
  endtask

  initial begin
    int      stall;
    result_t want;
    m_axis_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        stall = 300;
        hold_req = 1'b0;
      end else begin
        stall = recv_burst ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      if (pending_answers.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: found %0b answer %h", m_axis_tuser[0], m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        if (want.found !== m_axis_tuser[0] || want.answer !== m_axis_tdata) begin
          if (mismatch_count < 10)
            $display("mismatch: found exp %0b got %0b, answer exp %h got %h",
                     want.found, m_axis_tuser[0], want.answer, m_axis_tdata);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    row_t        row;
    sample_t     s;
    bit          mode;
    logic [16:0] frac;
    logic [31:0] total;
    longint      rows;
    longint      remaining;
    longint      up;
    longint      pc;
    longint      vcur;
    int          sel;
    int          n;
    int          sent;
    bit          paused;

    clk           = 1'b0;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    send_burst    = 1'b0;
    recv_burst    = 1'b0;
    hold_req      = 1'b0;
    mismatch_count = 0;
    cur_mode      = 1'b0;
    cur_fraction  = 17'h08000;
    cur_total     = 32'd1;
    open_group();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIR_ROWS; k++) begin
      row = dir_tab[k];
      if (row.kind == ROW_CONFIG) begin
        write_settings(row.gs, row.value[16:0], row.count);
      end else begin
        s.gs    = row.gs;
        s.nul   = row.nul;
        s.value = row.value;
        s.count = row.count;
        offer_sample(s, row.typed, '{row.exp_found, row.exp_answer});
      end
    end

    for (int phase = 0; phase < 11; phase++) begin
      mode = $urandom_range(0, 1);
      sel = $urandom_range(0, 9);
      if (phase == 0 || sel == 0) frac = 17'h00000;
      else if (phase == 1 || sel == 1) frac = 17'h10000;
      else if (sel == 2) frac = $urandom_range(17'h10001, 17'h1FFFF);
      else frac = $urandom_range(0, 17'h10000);
      sel = $urandom_range(0, 9);
      if (phase == 4 || sel == 0) total = 32'd1;
      else if (phase == 2 || sel == 1) total = 32'hFFFF_FFFF;
      else if (sel == 2) total = $urandom;
      else if (sel == 3) total = $urandom_range(1, 1000);
      else total = $urandom_range(1, 40);
      write_settings(mode, frac, total);

      send_burst = (phase % 4 == 1);
      recv_burst = (phase % 4 == 2);
      if (phase == 3) begin
        send_burst = 1'b1;
        hold_req   = 1'b1;
      end
      sent = 0;
      paused = 1'b0;
      while (sent < 100) begin
        if (phase == 6 && sent >= 50 && !paused) begin
          drain_results();
          paused = 1'b1;
        end
        rows = ($urandom_range(0, 5) == 0) ? longint'($urandom_range(1, 50)) :
               ((cur_total == 32'd0) ? 64'd1 : longint'(cur_total));
        n = (rows < 10) ? $urandom_range(1, int'(rows) + 1) : $urandom_range(1, 10);
        remaining = rows;
        vcur = longint'($signed($urandom));
        for (int i = 0; i < n; i++) begin
          s.gs  = (i == 0) && ($urandom_range(0, 14) != 0);
          s.nul = 1'b0;
          sel = $urandom_range(0, 19);
          if (sel == 0) begin
            s.gs    = ($urandom_range(0, 3) == 0);
            s.nul   = $urandom_range(0, 1);
            s.value = $urandom;
            s.count = $urandom;
          end else if (sel <= 2) begin
            s.nul   = 1'b1;
            s.value = $urandom;
            s.count = $urandom_range(0, 1) ? $urandom : remaining[31:0];
          end else begin
            up = 2 * remaining / (n - i);
            if (up > remaining) up = remaining;
            pc = (i == n - 1) ? remaining : longint'($urandom) % (up + 1);
            remaining -= pc;
            vcur += $urandom_range(0, 1 << $urandom_range(0, 24));
            if (vcur > 64'sh7FFF_FFFF) vcur = 64'sh7FFF_FFFF;
            s.value = vcur[31:0];
            s.count = pc[31:0];
          end
          offer_sample(s, 1'b0, '0);
          sent++;
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
